[hdl/ppgf_pkg.sv]
// Package with shared types, constants and codes of the PPG sample gate and filter.
package ppgf_pkg;

    localparam int WINDOW_LEN_DEF = 8;
    localparam int DIVISOR_W      = 8;
    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W     = 16;

    localparam logic [3:0]  BASE_SHIFT_RST  = 4'd4;
    localparam logic [15:0] WARMUP_RST      = 16'd40;
    localparam logic [15:0] GAP_FLOOR_RST   = 16'd75;
    localparam logic [7:0]  JUMP_DIV_RST    = 8'd10;
    localparam logic [15:0] JUMP_FLOOR_RST  = 16'd200;
    localparam logic [7:0]  SWING_DIV_RST   = 8'd12;
    localparam logic [15:0] SWING_FLOOR_RST = 16'd100;

    localparam logic [15:0] GAP_CLAMP = 16'hFFFF;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BASELINE_SHIFT = 3'd0,
        CFG_WARMUP_SAMPLES = 3'd1,
        CFG_MAX_GAP_FLOOR  = 3'd2,
        CFG_JUMP_DIVISOR   = 3'd3,
        CFG_JUMP_FLOOR     = 3'd4,
        CFG_SWING_DIVISOR  = 3'd5,
        CFG_SWING_FLOOR    = 3'd6
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV_JUMP,
        ST_DIV_SWING,
        ST_EVAL,
        ST_DIV_AVG,
        ST_FINISH
    } state_t;

endpackage

[hdl/ppgf_if.sv]
// Valid/ready channel interfaces for input items and result items.
interface ppgf_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [31:0] seq_num;
    logic [31:0] stamp_ms;
    logic [15:0] raw_sample;
    logic [7:0]  flags_in;

    modport source (output valid, func, seq_num, stamp_ms, raw_sample, flags_in, input ready);
    modport sink   (input valid, func, seq_num, stamp_ms, raw_sample, flags_in, output ready);
endinterface

interface ppgf_out_if;
    logic               valid;
    logic               ready;
    logic [31:0]        seq_out;
    logic [31:0]        stamp_out;
    logic [15:0]        raw_out;
    logic               sample_ok;
    logic [7:0]         flags_out;
    logic [15:0]        baseline_out;
    logic signed [16:0] ac_out;
    logic signed [16:0] filtered_out;

    modport source (output valid, seq_out, stamp_out, raw_out, sample_ok, flags_out,
                    baseline_out, ac_out, filtered_out, input ready);
    modport sink   (input valid, seq_out, stamp_out, raw_out, sample_ok, flags_out,
                    baseline_out, ac_out, filtered_out, output ready);
endinterface

[hdl/ppgf_div.sv]
// Shared restoring divider, one quotient bit per cycle.
module ppgf_div
    import ppgf_pkg::*;
#(
    parameter int DW = 21
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DW-1:0]        dividend,
    input  logic [DIVISOR_W-1:0] divisor,
    output logic                 done,
    output logic [DW-1:0]        quotient
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0]        quo_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] div_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 done_reg;
    logic [DIVISOR_W:0]   trial;
    logic                 ge;
    logic [DIVISOR_W:0]   diff;

    assign trial = {rem_reg, quo_reg[DW-1]};
    assign ge    = trial >= {1'b0, div_reg};
    assign diff  = trial - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            div_reg  <= '0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            quo_reg  <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
            cnt_reg  <= CW'(DW);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg  <= {quo_reg[DW-2:0], ge};
            rem_reg  <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == CW'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[hdl/ppg_sample_gate_and_filter.sv]
// Top level of the PPG sample gate, EMA baseline and moving average filter.
// Each item passes through the check step, the jump and swing threshold divisions and the
// evaluate step; an accepted sample then takes the averaging division, a rejected sample or
// a failed read skips it, and the finish step loads the output register. No new item is
// taken until then, and the finish step waits while that register holds an untaken result.
// Reset (rst_n, asynchronous, active low) loads the register defaults and clears all
// filter state; the window store itself is not cleared and needs no clearing pass.
module ppg_sample_gate_and_filter
    import ppgf_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    ppgf_in_if.sink                in_ch,
    ppgf_out_if.source             out_ch
);

    // Window arithmetic widths follow from the window length.
    localparam int PW    = $clog2(WINDOW_LEN);
    localparam int FW    = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W = 18 + $clog2(WINDOW_LEN);

    // Configuration registers.
    logic [3:0]  base_shift_reg;
    logic [15:0] warmup_reg;
    logic [15:0] gap_floor_reg;
    logic [7:0]  jump_div_reg;
    logic [15:0] jump_floor_reg;
    logic [7:0]  swing_div_reg;
    logic [15:0] swing_floor_reg;

    // Latched input item.
    logic        func_reg;
    logic [31:0] seq_reg;
    logic [31:0] stamp_reg;
    logic [15:0] raw_reg;
    logic [7:0]  flags_reg;

    // Filter state.
    logic [23:0]             baseline_q8_reg;
    logic [15:0]             valid_count_reg;
    logic [15:0]             last_good_raw_reg;
    logic                    last_good_known_reg;
    logic [31:0]             prev_seq_reg;
    logic [31:0]             prev_stamp_reg;
    logic                    prev_seen_reg;
    logic [23:0]             interval_q8_reg;
    logic signed [SUM_W-1:0] window_sum_reg;
    logic [FW-1:0]           fill_reg;
    logic [PW-1:0]           pos_reg;
    logic signed [16:0]      last_filt_reg;

    // Window store, registered read.
    logic signed [17:0] window_mem [WINDOW_LEN];
    logic signed [17:0] old_entry_reg;

    // Per-item working values.
    logic        seq_err_reg;
    logic        stamp_err_reg;
    logic [15:0] jump_thr_reg;
    logic [15:0] swing_thr_reg;
    logic        neg_reg;

    // Result being assembled.
    logic               res_ok_reg;
    logic [7:0]         res_flags_reg;
    logic [15:0]        res_base_reg;
    logic signed [16:0] res_ac_reg;
    logic signed [16:0] res_filt_reg;

    // Output register.
    logic               out_valid_reg;
    logic [31:0]        out_seq_reg;
    logic [31:0]        out_stamp_reg;
    logic [15:0]        out_raw_reg;
    logic               out_ok_reg;
    logic [7:0]         out_flags_reg;
    logic [15:0]        out_base_reg;
    logic signed [16:0] out_ac_reg;
    logic signed [16:0] out_filt_reg;

    state_t state_reg, state_next;

    // Shared divider.
    logic                 div_start;
    logic [SUM_W-1:0]     div_dividend;
    logic [DIVISOR_W-1:0] div_divisor;
    logic                 div_done;
    logic [SUM_W-1:0]     div_q;

    ppgf_div #(.DW(SUM_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // The baseline reads as zero until the first sample has been accepted.
    logic        first;
    logic [15:0] cur_base;
    assign first    = (valid_count_reg == '0);
    assign cur_base = first ? 16'd0 : baseline_q8_reg[23:8];

    // Sequence and timestamp checks, done in the check step.
    logic        seq_err_c;
    logic        stamp_le;
    logic [31:0] delta;
    logic [17:0] scaled_iv;
    logic [31:0] gap_thr;
    logic        stamp_err_c;
    logic [15:0] delta_clamp;
    logic [23:0] gap_target;
    logic [26:0] iv_mix;
    logic [23:0] iv_next;

    always_comb
    begin
        seq_err_c   = prev_seen_reg && (seq_reg != prev_seq_reg + 32'd1);
        stamp_le    = stamp_reg <= prev_stamp_reg;
        delta       = stamp_reg - prev_stamp_reg;
        scaled_iv   = {2'b00, interval_q8_reg[23:8]} + {1'b0, interval_q8_reg[23:8], 1'b0};
        gap_thr     = {16'd0, gap_floor_reg};
        if ((interval_q8_reg != '0) && ({14'd0, scaled_iv} > gap_thr))
        begin
            gap_thr = {14'd0, scaled_iv};
        end
        stamp_err_c = prev_seen_reg && (stamp_le || (delta > gap_thr));
        delta_clamp = (delta > {16'd0, GAP_CLAMP}) ? GAP_CLAMP : delta[15:0];
        gap_target  = {delta_clamp, 8'd0};
        iv_mix      = ({interval_q8_reg, 3'b000} - {3'b000, interval_q8_reg})
                      + {3'b000, gap_target};
        iv_next     = (interval_q8_reg == '0) ? gap_target : iv_mix[26:3];
    end

    // Acceptance decision and filter update, done in the evaluate step.
    logic signed [17:0]      ac_pre;
    logic [15:0]             jump_d;
    logic                    jump_bad;
    logic signed [17:0]      swing_t;
    logic                    swing_bad;
    logic                    pre_ok;
    logic                    good;
    logic                    outlier;
    logic [23:0]             base_target;
    logic signed [25:0]      base_diff;
    logic signed [25:0]      base_step;
    logic [23:0]             bq8_new;
    logic [15:0]             base_new;
    logic signed [17:0]      ac_new;
    logic                    full;
    logic signed [SUM_W-1:0] sum_new;
    logic [FW-1:0]           fill_new;
    logic [15:0]             count_new;
    logic [SUM_W-1:0]        sum_mag;

    always_comb
    begin
        ac_pre      = $signed({2'b00, raw_reg}) - $signed({2'b00, cur_base});
        jump_d      = (raw_reg >= last_good_raw_reg) ? raw_reg - last_good_raw_reg
                                                     : last_good_raw_reg - raw_reg;
        jump_bad    = last_good_known_reg && (jump_d > jump_thr_reg);
        swing_t     = $signed({2'b00, swing_thr_reg});
        swing_bad   = !first && ((ac_pre > swing_t) || (ac_pre < -swing_t));
        pre_ok      = (raw_reg != '0) && !seq_err_reg && !stamp_err_reg;
        good        = !func_reg && pre_ok && !jump_bad && !swing_bad;
        outlier     = !func_reg && ((raw_reg == '0) || (pre_ok && (jump_bad || swing_bad)));
        base_target = {raw_reg, 8'd0};
        base_diff   = $signed({2'b00, base_target}) - $signed({2'b00, baseline_q8_reg});
        // Arithmetic shift right floors, as the EMA step requires.
        base_step   = base_diff >>> base_shift_reg;
        bq8_new     = first ? base_target : (baseline_q8_reg + base_step[23:0]);
        base_new    = bq8_new[23:8];
        ac_new      = $signed({2'b00, raw_reg}) - $signed({2'b00, base_new});
        full        = (fill_reg == FW'(WINDOW_LEN));
        sum_new     = window_sum_reg + SUM_W'(ac_new);
        if (full)
        begin
            sum_new = sum_new - SUM_W'(old_entry_reg);
        end
        fill_new    = full ? fill_reg : fill_reg + 1'b1;
        count_new   = (valid_count_reg == COUNT_MAX) ? COUNT_MAX : valid_count_reg + 16'd1;
        sum_mag     = sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);
    end

    // Sequencer: next state and divider operands.
    always_comb
    begin
        state_next   = state_reg;
        div_start    = 1'b0;
        div_dividend = SUM_W'(cur_base);
        div_divisor  = (jump_div_reg == '0) ? DIVISOR_W'(1) : jump_div_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_JUMP;
            end
            ST_DIV_JUMP:
            begin
                div_divisor = (swing_div_reg == '0) ? DIVISOR_W'(1) : swing_div_reg;
                if (div_done)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV_SWING;
                end
            end
            ST_DIV_SWING:
            begin
                if (div_done)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                div_dividend = sum_mag;
                div_divisor  = DIVISOR_W'(fill_new);
                if (good)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV_AVG;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_DIV_AVG:
            begin
                if (div_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_shift_reg  <= BASE_SHIFT_RST;
            warmup_reg      <= WARMUP_RST;
            gap_floor_reg   <= GAP_FLOOR_RST;
            jump_div_reg    <= JUMP_DIV_RST;
            jump_floor_reg  <= JUMP_FLOOR_RST;
            swing_div_reg   <= SWING_DIV_RST;
            swing_floor_reg <= SWING_FLOOR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_BASELINE_SHIFT: base_shift_reg  <= cfg_wdata[3:0];
                CFG_WARMUP_SAMPLES: warmup_reg      <= cfg_wdata;
                CFG_MAX_GAP_FLOOR:  gap_floor_reg   <= cfg_wdata;
                CFG_JUMP_DIVISOR:   jump_div_reg    <= cfg_wdata[7:0];
                CFG_JUMP_FLOOR:     jump_floor_reg  <= cfg_wdata;
                CFG_SWING_DIVISOR:  swing_div_reg   <= cfg_wdata[7:0];
                CFG_SWING_FLOOR:    swing_floor_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Window store: the oldest entry is read in the check step and the slot is
    // rewritten when a sample is accepted.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CHECK)
        begin
            old_entry_reg <= window_mem[pos_reg];
        end
        if ((state_reg == ST_EVAL) && good)
        begin
            window_mem[pos_reg] <= ac_new;
        end
    end

    // Item capture, per-step working registers and filter state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baseline_q8_reg     <= '0;
            valid_count_reg     <= '0;
            last_good_raw_reg   <= '0;
            last_good_known_reg <= 1'b0;
            prev_seq_reg        <= '0;
            prev_stamp_reg      <= '0;
            prev_seen_reg       <= 1'b0;
            interval_q8_reg     <= '0;
            window_sum_reg      <= '0;
            fill_reg            <= '0;
            pos_reg             <= '0;
            last_filt_reg       <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            // In the finish step the output register is handled below.
            if (out_valid_reg && out_ch.ready && (state_reg != ST_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        func_reg  <= in_ch.func;
                        seq_reg   <= in_ch.seq_num;
                        stamp_reg <= in_ch.stamp_ms;
                        raw_reg   <= in_ch.raw_sample;
                        flags_reg <= in_ch.flags_in;
                    end
                end
                ST_CHECK:
                begin
                    // A gap that passes is folded into the interval for any item.
                    seq_err_reg   <= seq_err_c;
                    stamp_err_reg <= stamp_err_c;
                    if (prev_seen_reg && !stamp_err_c)
                    begin
                        interval_q8_reg <= iv_next;
                    end
                    prev_seq_reg   <= seq_reg;
                    prev_stamp_reg <= stamp_reg;
                    prev_seen_reg  <= 1'b1;
                end
                ST_DIV_JUMP:
                begin
                    if (div_done)
                    begin
                        jump_thr_reg <= (div_q[15:0] < jump_floor_reg) ? jump_floor_reg
                                                                         : div_q[15:0];
                    end
                end
                ST_DIV_SWING:
                begin
                    if (div_done)
                    begin
                        swing_thr_reg <= (div_q[15:0] < swing_floor_reg) ? swing_floor_reg
                                                                           : div_q[15:0];
                    end
                end
                ST_EVAL:
                begin
                    res_ok_reg    <= good;
                    res_filt_reg  <= last_filt_reg;
                    res_flags_reg <= flags_reg | {3'b000,
                                                  good && (fill_new == FW'(WINDOW_LEN)),
                                                  good && (count_new <= warmup_reg),
                                                  stamp_err_reg, seq_err_reg, outlier};
                    if (func_reg)
                    begin
                        // Failed read: current baseline, no AC value.
                        res_base_reg <= cur_base;
                        res_ac_reg   <= '0;
                    end
                    else if (good)
                    begin
                        res_base_reg        <= base_new;
                        res_ac_reg          <= ac_new[16:0];
                        baseline_q8_reg     <= bq8_new;
                        window_sum_reg      <= sum_new;
                        fill_reg            <= fill_new;
                        pos_reg             <= (pos_reg == PW'(WINDOW_LEN - 1)) ? '0
                                                                              : pos_reg + 1'b1;
                        valid_count_reg     <= count_new;
                        last_good_raw_reg   <= raw_reg;
                        last_good_known_reg <= 1'b1;
                        neg_reg             <= sum_new[SUM_W-1];
                    end
                    else
                    begin
                        // Rejected: the first sample still reports its own reading.
                        res_base_reg <= first ? raw_reg : cur_base;
                        res_ac_reg   <= first ? 17'sd0 : ac_pre[16:0];
                    end
                end
                ST_DIV_AVG:
                begin
                    if (div_done)
                    begin
                        // Average truncates toward zero: divide the magnitude.
                        res_filt_reg  <= neg_reg ? -$signed(div_q[16:0]) : $signed(div_q[16:0]);
                        last_filt_reg <= neg_reg ? -$signed(div_q[16:0]) : $signed(div_q[16:0]);
                    end
                end
                ST_FINISH:
                begin
                    if (!out_valid_reg || out_ch.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_seq_reg   <= seq_reg;
                        out_stamp_reg <= stamp_reg;
                        out_raw_reg   <= func_reg ? 16'd0 : raw_reg;
                        out_ok_reg    <= res_ok_reg;
                        out_flags_reg <= res_flags_reg;
                        out_base_reg  <= res_base_reg;
                        out_ac_reg    <= res_ac_reg;
                        out_filt_reg  <= res_filt_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    assign in_ch.ready         = (state_reg == ST_IDLE);
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.seq_out      = out_seq_reg;
    assign out_ch.stamp_out    = out_stamp_reg;
    assign out_ch.raw_out      = out_raw_reg;
    assign out_ch.sample_ok    = out_ok_reg;
    assign out_ch.flags_out    = out_flags_reg;
    assign out_ch.baseline_out = out_base_reg;
    assign out_ch.ac_out       = out_ac_reg;
    assign out_ch.filtered_out = out_filt_reg;

endmodule

[tb/ppg_sample_gate_and_filter_tb.sv]
// Self-checking testbench of the PPG sample gate and filter.
module ppg_sample_gate_and_filter_tb;
    import ppgf_pkg::*;

    // The run is stopped once the cycle count passes this limit.
    localparam int CYCLE_LIMIT = 2000000;
    localparam int WIN         = WINDOW_LEN_DEF;
    localparam int DRAIN_WAIT  = 80;

    // One input item as the sender drives it.
    typedef struct {
        logic        func;
        logic [31:0] seq_num;
        logic [31:0] stamp_ms;
        logic [15:0] raw_sample;
        logic [7:0]  flags_in;
    } ppg_sample_t;

    // One result item as the block should present it.
    typedef struct {
        logic [31:0]        seq_out;
        logic [31:0]        stamp_out;
        logic [15:0]        raw_out;
        logic               sample_ok;
        logic [7:0]         flags_out;
        logic [15:0]        baseline_out;
        logic signed [16:0] ac_out;
        logic signed [16:0] filtered_out;
    } ppg_result_t;

    // Flag bits that the block adds to the incoming flags.
    localparam logic [7:0] FL_OUTLIER = 8'h01;
    localparam logic [7:0] FL_SEQ     = 8'h02;
    localparam logic [7:0] FL_STAMP   = 8'h04;
    localparam logic [7:0] FL_WARMUP  = 8'h08;
    localparam logic [7:0] FL_READY   = 8'h10;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    ppgf_in_if  in_ch ();
    ppgf_out_if out_ch ();

    ppg_sample_gate_and_filter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Register copies held by the predictor.
    logic [3:0]  base_shift;
    logic [15:0] warmup_len;
    logic [15:0] gap_floor;
    logic [7:0]  jump_div;
    logic [15:0] jump_floor;
    logic [7:0]  swing_div;
    logic [15:0] swing_floor;

    // Filter state held by the predictor.
    logic [31:0] base_q8;
    logic [31:0] good_count;
    logic [15:0] last_raw;
    logic        last_raw_known;
    logic [31:0] last_seq;
    logic [31:0] last_stamp;
    logic        seen_any;
    logic [31:0] period_q8;
    int          ring [WIN];
    longint      ring_sum;
    int          ring_fill;
    int          ring_pos;
    int          last_avg;

    // Results still owed by the block, oldest first.
    ppg_result_t pending_results [$];

    int errors;
    int cycles;
    int src_idle_pct;
    int snk_idle_pct;

    // State of the stimulus generator: the last sequence and stamp sent and the
    // signal level that well-formed samples wander around.
    logic [31:0] gen_seq;
    logic [31:0] gen_stamp;
    int          gen_level;

    always #5 clk = ~clk;

    // The run is bounded so that a hung block cannot stall it forever.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("** ppg_sample_gate_and_filter: FAILED **");
            $finish;
        end
    end

    // The receiver stalls at random, at the rate of the current phase.
    always @(negedge clk)
    begin
        if (rst_n)
            out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    function automatic logic [31:0] current_base();
        return (good_count == 0) ? 32'd0 : (base_q8 >> 8);
    endfunction

    // Threshold scaled from the baseline, never below its floor. A zero divisor
    // behaves as one.
    function automatic logic [31:0] scaled_limit(logic [7:0] div, logic [15:0] lim_floor);
        logic [31:0] d;
        logic [31:0] t;
        d = (div == 0) ? 32'd1 : {24'd0, div};
        t = current_base() / d;
        return (t < lim_floor) ? {16'd0, lim_floor} : t;
    endfunction

    function automatic logic seq_broken(logic [31:0] seq);
        logic [31:0] next_seq;
        next_seq = last_seq + 32'd1;
        return seen_any && (seq != next_seq);
    endfunction

    // Checks the timestamp gap. A gap that passes is folded into the smoothed
    // interval, clamped to 16 bits of milliseconds.
    function automatic logic stamp_broken(logic [31:0] stamp);
        logic [31:0] gap;
        logic [31:0] limit;
        logic [31:0] scaled;
        if (!seen_any)
            return 1'b0;
        if (stamp <= last_stamp)
            return 1'b1;
        gap = stamp - last_stamp;
        limit = {16'd0, gap_floor};
        if (period_q8 != 0)
        begin
            scaled = (period_q8 >> 8) * 32'd3;
            if (scaled > limit)
                limit = scaled;
        end
        if (gap > limit)
            return 1'b1;
        if (gap > 32'd65535)
            gap = 32'd65535;
        if (period_q8 == 0)
            period_q8 = gap << 8;
        else
            period_q8 = (period_q8 * 32'd7 + (gap << 8)) / 32'd8;
        return 1'b0;
    endfunction

    // Works out the result of one item and advances the filter state.
    function automatic ppg_result_t gate_and_filter(ppg_sample_t s);
        ppg_result_t r;
        logic [31:0] base;
        logic [31:0] jump_dist;
        logic [31:0] target;
        logic [7:0]  fl;
        logic        good;
        int          ac;
        int          avg;
        int          lim;
        int          diff;

        fl = s.flags_in;
        avg = last_avg;
        ac = 0;
        good = 1'b0;
        base = current_base();
        r.raw_out = 16'd0;
        if (s.func)
        begin
            if (seq_broken(s.seq_num))
                fl |= FL_SEQ;
            if (stamp_broken(s.stamp_ms))
                fl |= FL_STAMP;
        end
        else
        begin
            good = 1'b1;
            r.raw_out = s.raw_sample;
            ac = int'(s.raw_sample) - int'(base);
            if (good_count == 0)
            begin
                base = {16'd0, s.raw_sample};
                ac = 0;
            end
            if (s.raw_sample == 0)
            begin
                good = 1'b0;
                fl |= FL_OUTLIER;
            end
            if (seq_broken(s.seq_num))
            begin
                good = 1'b0;
                fl |= FL_SEQ;
            end
            if (stamp_broken(s.stamp_ms))
            begin
                good = 1'b0;
                fl |= FL_STAMP;
            end
            if (good && last_raw_known)
            begin
                jump_dist = (s.raw_sample >= last_raw) ? s.raw_sample - last_raw
                                                       : last_raw - s.raw_sample;
                if (jump_dist > scaled_limit(jump_div, jump_floor))
                begin
                    good = 1'b0;
                    fl |= FL_OUTLIER;
                end
            end
            if (good && good_count != 0)
            begin
                lim = int'(scaled_limit(swing_div, swing_floor));
                if (ac > lim || ac < -lim)
                begin
                    good = 1'b0;
                    fl |= FL_OUTLIER;
                end
            end
            if (good)
            begin
                // The EMA step rounds toward minus infinity, as an arithmetic shift does.
                target = {8'd0, s.raw_sample, 8'd0};
                if (good_count == 0)
                    base_q8 = target;
                else
                begin
                    diff = int'(target) - int'(base_q8);
                    base_q8 = 32'(int'(base_q8) + (diff >>> base_shift));
                end
                base_q8 &= 32'h00FF_FFFF;
                base = base_q8 >> 8;
                ac = int'(s.raw_sample) - int'(base);
                if (ring_fill < WIN)
                    ring_fill++;
                else
                    ring_sum -= ring[ring_pos];
                ring[ring_pos] = ac;
                ring_sum += ac;
                ring_pos = (ring_pos + 1) % WIN;
                avg = int'(ring_sum / ring_fill);
                if (good_count < 32'd65535)
                    good_count++;
                if (good_count <= warmup_len)
                    fl |= FL_WARMUP;
                if (ring_fill >= WIN)
                    fl |= FL_READY;
                last_raw = s.raw_sample;
                last_raw_known = 1'b1;
                last_avg = avg;
            end
        end
        last_seq = s.seq_num;
        last_stamp = s.stamp_ms;
        seen_any = 1'b1;

        r.seq_out = s.seq_num;
        r.stamp_out = s.stamp_ms;
        r.sample_ok = good;
        r.flags_out = fl;
        r.baseline_out = base[15:0];
        r.ac_out = ac[16:0];
        r.filtered_out = avg[16:0];
        return r;
    endfunction

    task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: mismatch on %s: expected 0x%0h, actual 0x%0h", $time, field, want, got);
            errors++;
        end
    endtask

    // Every result taken by the receiver is checked against the oldest prediction.
    always @(posedge clk)
    begin
        ppg_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with no item waiting, expected none, actual seq 0x%0h",
                         $time, out_ch.seq_out);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("seq_out", want.seq_out, out_ch.seq_out);
                compare_field("stamp_out", want.stamp_out, out_ch.stamp_out);
                compare_field("raw_out", {16'd0, want.raw_out}, {16'd0, out_ch.raw_out});
                compare_field("sample_ok", {31'd0, want.sample_ok}, {31'd0, out_ch.sample_ok});
                compare_field("flags_out", {24'd0, want.flags_out}, {24'd0, out_ch.flags_out});
                compare_field("baseline_out", {16'd0, want.baseline_out},
                              {16'd0, out_ch.baseline_out});
                compare_field("ac_out", {15'd0, want.ac_out}, {15'd0, out_ch.ac_out});
                compare_field("filtered_out", {15'd0, want.filtered_out},
                              {15'd0, out_ch.filtered_out});
            end
        end
    end

    // Sends one item, with a random gap before it at the sender's idle rate.
    // Valid stays high from one item to the next unless a gap is taken.
    task automatic send_sample(logic func, logic [31:0] seq, logic [31:0] stamp,
                               logic [15:0] raw, logic [7:0] flags);
        ppg_sample_t s;
        s.func = func;
        s.seq_num = seq;
        s.stamp_ms = stamp;
        s.raw_sample = raw;
        s.flags_in = flags;
        @(negedge clk);
        if ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.func       <= func;
        in_ch.seq_num    <= seq;
        in_ch.stamp_ms   <= stamp;
        in_ch.raw_sample <= raw;
        in_ch.flags_in   <= flags;
        do
            @(posedge clk);
        while (!in_ch.ready);
        pending_results.push_back(gate_and_filter(s));
        gen_seq = seq;
        gen_stamp = stamp;
    endtask

    // Lets every owed result arrive, then lets the block settle to idle.
    task automatic drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [15:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_BASELINE_SHIFT: base_shift  = value[3:0];
            CFG_WARMUP_SAMPLES: warmup_len  = value;
            CFG_MAX_GAP_FLOOR:  gap_floor   = value;
            CFG_JUMP_DIVISOR:   jump_div    = value[7:0];
            CFG_JUMP_FLOOR:     jump_floor  = value;
            CFG_SWING_DIVISOR:  swing_div   = value[7:0];
            CFG_SWING_FLOOR:    swing_floor = value;
            default: ;
        endcase
    endtask

    task automatic write_all(logic [15:0] shift, logic [15:0] warm, logic [15:0] gapf,
                             logic [15:0] jdiv, logic [15:0] jfl, logic [15:0] sdiv,
                             logic [15:0] sfl);
        write_reg(CFG_BASELINE_SHIFT, shift);
        write_reg(CFG_WARMUP_SAMPLES, warm);
        write_reg(CFG_MAX_GAP_FLOOR, gapf);
        write_reg(CFG_JUMP_DIVISOR, jdiv);
        write_reg(CFG_JUMP_FLOOR, jfl);
        write_reg(CFG_SWING_DIVISOR, sdiv);
        write_reg(CFG_SWING_FLOOR, sfl);
    endtask

    // Mostly well-formed streams around a wandering level, with failed reads,
    // glitches and fully random items mixed in.
    task automatic random_stream(int count, int src_pct, int snk_pct);
        int pick;
        int raw;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        gen_level = $urandom_range(500, 60000);
        repeat (count)
        begin
            pick = $urandom_range(99);
            if ($urandom_range(49) == 0)
                gen_level = $urandom_range(500, 60000);
            raw = gen_level + $urandom_range(0, 2 * (gen_level / 40 + 10)) - (gen_level / 40 + 10);
            if (raw < 1)
                raw = 1;
            if (raw > 65535)
                raw = 65535;
            if (pick < 78)
                send_sample(1'b0, gen_seq + 1, gen_stamp + $urandom_range(10, 40), raw[15:0],
                            ($urandom_range(4) == 0) ? 8'($urandom) : 8'd0);
            else if (pick < 84)
                send_sample(1'b1, gen_seq + 1, gen_stamp + $urandom_range(10, 40),
                            16'($urandom), 8'($urandom));
            else if (pick < 90)
                // A random reading, most often a spike or a dip far from the level.
                send_sample(1'b0, gen_seq + 1, gen_stamp + $urandom_range(10, 40),
                            16'($urandom_range(0, 65535)), 8'd0);
            else if (pick < 94)
                // A lost or repeated sample, or a late one.
                send_sample(1'b0, gen_seq + $urandom_range(0, 3),
                            gen_stamp + $urandom_range(0, 400), raw[15:0], 8'd0);
            else
                send_sample(1'($urandom), $urandom, $urandom, 16'($urandom), 8'($urandom));
        end
    endtask

    // Directed items on the reset settings: the first sample, failed reads,
    // each reject reason, a full window, field extremes and counter wraps.
    task automatic test_directed();
        int k;
        src_idle_pct = 21;
        snk_idle_pct = 66;
        send_sample(1'b1, 32'd100, 32'd1000, 16'hFFFF, 8'd0);
        send_sample(1'b0, 32'd101, 32'd1020, 16'd2000, 8'hFF);
        for (k = 0; k < 9; k++)
            send_sample(1'b0, gen_seq + 1, gen_stamp + 20, 16'd1990 + 16'(k * 4), 8'd0);
        send_sample(1'b0, gen_seq + 1, gen_stamp + 20, 16'd0, 8'd0);
        send_sample(1'b0, gen_seq + 2, gen_stamp + 20, 16'd2000, 8'd0);
        send_sample(1'b0, gen_seq + 1, gen_stamp, 16'd2000, 8'd0);
        send_sample(1'b0, gen_seq + 1, gen_stamp - 5, 16'd2000, 8'd0);
        send_sample(1'b0, gen_seq + 1, gen_stamp + 5000, 16'd2000, 8'd0);
        send_sample(1'b0, gen_seq + 1, gen_stamp + 20, 16'd2900, 8'd0);
        // Small enough a jump, but too far from the baseline.
        send_sample(1'b0, gen_seq + 1, gen_stamp + 20, 16'd2190, 8'd0);
        send_sample(1'b0, gen_seq + 1, gen_stamp + 20, 16'hFFFF, 8'd0);
        send_sample(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFE0, 16'd2000, 8'd0);
        send_sample(1'b0, 32'd0, 32'hFFFF_FFF5, 16'd2004, 8'd0);
        send_sample(1'b1, 32'd1, 32'hFFFF_FFFF, 16'd0, 8'h80);
        send_sample(1'b0, 32'd2, 32'd0, 16'd2000, 8'd0);
        drain();
    endtask

    task automatic test_reset_settings();
        random_stream(300, 21, 66);
        drain();
    endtask

    // Fastest baseline, no warmup, widest gap, a jump limit as wide as the baseline, tightest swing limit.
    task automatic test_fast_tight();
        write_all(16'd0, 16'd0, 16'hFFFF, 16'd1, 16'd0, 16'd255, 16'd0);
        random_stream(300, 66, 21);
        drain();
    endtask

    // Slowest baseline, endless warmup, narrowest gap floor, loosest limits.
    task automatic test_slow_loose();
        write_all(16'd15, 16'hFFFF, 16'd1, 16'd255, 16'hFFFF, 16'd1, 16'hFFFF);
        random_stream(300, 0, 0);
        drain();
    endtask

    // Zero divisors count as one; a zero gap floor leans on the smoothed interval.
    task automatic test_zero_settings();
        write_all(16'd7, 16'd3, 16'd0, 16'd0, 16'd300, 16'd0, 16'd400);
        random_stream(250, 21, 66);
        drain();
    endtask

    task automatic test_mid_settings();
        write_all(16'd2, 16'd100, 16'd200, 16'd20, 16'd1000, 16'd8, 16'd1500);
        random_stream(250, 66, 21);
        drain();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_BASELINE_SHIFT;
        cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.func = 1'b0;
        in_ch.seq_num = '0;
        in_ch.stamp_ms = '0;
        in_ch.raw_sample = '0;
        in_ch.flags_in = '0;
        out_ch.ready = 1'b0;
        errors = 0;
        cycles = 0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        gen_seq = '0;
        gen_stamp = '0;
        gen_level = 2000;

        // The predictor starts from the reset state of the block.
        base_shift = BASE_SHIFT_RST;
        warmup_len = WARMUP_RST;
        gap_floor = GAP_FLOOR_RST;
        jump_div = JUMP_DIV_RST;
        jump_floor = JUMP_FLOOR_RST;
        swing_div = SWING_DIV_RST;
        swing_floor = SWING_FLOOR_RST;
        base_q8 = '0;
        good_count = '0;
        last_raw = '0;
        last_raw_known = 1'b0;
        last_seq = '0;
        last_stamp = '0;
        seen_any = 1'b0;
        period_q8 = '0;
        ring_sum = 0;
        ring_fill = 0;
        ring_pos = 0;
        last_avg = 0;
        foreach (ring[k])
            ring[k] = 0;

        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_reset_settings();
        test_fast_tight();
        test_slow_loose();
        test_zero_settings();
        test_mid_settings();

        if (errors == 0)
            $display("** ppg_sample_gate_and_filter: PASSED **");
        else
            $display("** ppg_sample_gate_and_filter: FAILED **");
        $finish;
    end

endmodule
